/* hdl/ggc_pkg.sv */
package ggc_pkg;

  // Q.31 fixed point, 1.0 = 2^31
  localparam int FX      = 31;
  localparam int PW      = 32;
  localparam int CFG_IW  = 2;
  localparam int CFG_DW  = 16;

  // register indexes
  localparam logic [CFG_IW-1:0] REG_WEIGHT_RED   = 2'd0;
  localparam logic [CFG_IW-1:0] REG_WEIGHT_GREEN = 2'd1;
  localparam logic [CFG_IW-1:0] REG_WEIGHT_BLUE  = 2'd2;
  localparam logic [CFG_IW-1:0] REG_GAMMA_VALUE  = 2'd3;

  // 2^32 - 1 = 255 * RECIP_255
  localparam logic [24:0] RECIP_255 = 25'd16843009;

  // payload carried through the power pipeline
  typedef struct packed {
    logic          dz;  // gray level is zero
    logic [PW-1:0] p;   // running product
    logic [PW-1:0] r;   // current root of x
  } pw_t;

endpackage

/* hdl/ggc_mean.sv */
module ggc_mean import ggc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              vld_i,
  input  logic [7:0]        red_i,
  input  logic [7:0]        green_i,
  input  logic [7:0]        blue_i,
  input  logic [CFG_DW-1:0] w_red,
  input  logic [CFG_DW-1:0] w_green,
  input  logic [CFG_DW-1:0] w_blue,
  output logic              vld_o,
  output logic [7:0]        d_o
);

  localparam int NW = 26;
  localparam int DW = 18;

  logic [8:0]    v_r;
  logic [NW-1:0] rem_r [9];
  logic [DW-1:0] den_r [9];
  logic [7:0]    q_r   [9];

  logic [NW-1:0] num_nxt;
  logic [DW-1:0] den_nxt;

  // weighted sum; a zero weight sum divides 0 by 1
  always_comb begin
    den_nxt = DW'(w_red) + DW'(w_green) + DW'(w_blue);
    num_nxt = NW'(w_red) * NW'(red_i) + NW'(w_green) * NW'(green_i)
            + NW'(w_blue) * NW'(blue_i);
    if (den_nxt == '0) begin
      den_nxt = DW'(1);
      num_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= num_nxt;
      den_r[0] <= den_nxt;
      q_r[0]   <= '0;
    end
  end

  // restoring divide, one quotient bit per stage
  for (genvar j = 0; j < 8; j++) begin : g_div
    logic [NW-1:0] dsh;
    logic          ge;
    assign dsh = NW'(den_r[j]) << (7 - j);
    assign ge  = rem_r[j] >= dsh;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[j+1] <= 1'b0;
      end else if (en) begin
        v_r[j+1] <= v_r[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j+1] <= ge ? rem_r[j] - dsh : rem_r[j];
        den_r[j+1] <= den_r[j];
        q_r[j+1]   <= q_r[j] | (ge ? (8'd1 << (7 - j)) : 8'd0);
      end
    end
  end

  assign vld_o = v_r[8];
  assign d_o   = q_r[8];

endmodule

/* hdl/ggc_fxmul.sv */
module ggc_fxmul import ggc_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic en,
  input  logic vld_i,
  input  pw_t  d_i,
  input  logic do_mul,
  output logic vld_o,
  output pw_t  d_o
);

  logic [2*PW-1:0] prod;
  pw_t             d_nxt;

  // p' = floor(p * r / 2^31) when selected
  always_comb begin
    prod  = (2*PW)'(d_i.p) * (2*PW)'(d_i.r);
    d_nxt = d_i;
    if (do_mul) begin
      d_nxt.p = prod[FX+PW-1:FX];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_o <= 1'b0;
    end else if (en) begin
      vld_o <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_o <= d_nxt;
    end
  end

endmodule

/* hdl/ggc_isqrt.sv */
module ggc_isqrt import ggc_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic en,
  input  logic vld_i,
  input  pw_t  d_i,
  output logic vld_o,
  output pw_t  d_o
);

  // r' = floor(sqrt(r * 2^31)), one result bit per stage
  localparam int NS = 32;

  logic [NS:0] v;
  pw_t         s   [NS+1];
  logic [63:0] n   [NS+1];
  logic [63:0] res [NS+1];

  assign v[0]   = vld_i;
  assign s[0]   = d_i;
  assign n[0]   = {1'b0, d_i.r, 31'b0};
  assign res[0] = '0;

  for (genvar j = 0; j < NS; j++) begin : g_step
    localparam logic [63:0] BIT = 64'd1 << (62 - 2*j);
    logic [63:0] trial;
    logic        ge;
    assign trial = res[j] + BIT;
    assign ge    = n[j] >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v[j+1] <= 1'b0;
      end else if (en) begin
        v[j+1] <= v[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        s[j+1]   <= s[j];
        n[j+1]   <= ge ? n[j] - trial : n[j];
        res[j+1] <= ge ? (res[j] >> 1) + BIT : res[j] >> 1;
      end
    end
  end

  always_comb begin
    d_o   = s[NS];
    d_o.r = res[NS][PW-1:0];
  end
  assign vld_o = v[NS];

endmodule

/* hdl/ggc_power.sv */
module ggc_power import ggc_pkg::*; #(
  parameter int INT_BITS  = 4,
  parameter int FRAC_BITS = 12
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          vld_i,
  input  logic [7:0]                    d_i,
  input  logic [INT_BITS+FRAC_BITS-1:0] gm,
  output logic                          vld_o,
  output pw_t                           d_o
);

  localparam int IMAX = (1 << INT_BITS) - 1;

  logic [32:0]         t;
  pw_t                 x_nxt;
  logic [INT_BITS-1:0] ipart;

  logic iv [IMAX+1];
  pw_t  ip [IMAX+1];
  logic fv [FRAC_BITS+1];
  pw_t  fp [FRAC_BITS+1];

  // x = ceil(d * 2^31 / 255) = floor(d * RECIP_255 / 2) + 1 for d > 0
  always_comb begin
    t       = 33'(d_i) * 33'(RECIP_255);
    x_nxt.p = PW'(1) << FX;
    x_nxt.r = t[32:1] + PW'(1);
    x_nxt.dz = (d_i == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iv[0] <= 1'b0;
    end else if (en) begin
      iv[0] <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ip[0] <= x_nxt;
    end
  end

  assign ipart = gm[INT_BITS+FRAC_BITS-1:FRAC_BITS];

  // integer part of gamma: one multiply by x per stage, done only while k is below the integer part
  for (genvar k = 0; k < IMAX; k++) begin : g_int
    ggc_fxmul u_mul (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .vld_i  (iv[k]),
      .d_i    (ip[k]),
      .do_mul (ipart > INT_BITS'(k)),
      .vld_o  (iv[k+1]),
      .d_o    (ip[k+1])
    );
  end

  assign fv[0] = iv[IMAX];
  assign fp[0] = ip[IMAX];

  // fraction bits: next root, then multiply if the bit is set
  for (genvar k = 1; k <= FRAC_BITS; k++) begin : g_frac
    logic sv;
    pw_t  sp;

    ggc_isqrt u_sqrt (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .vld_i (fv[k-1]),
      .d_i   (fp[k-1]),
      .vld_o (sv),
      .d_o   (sp)
    );

    ggc_fxmul u_mul (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .vld_i  (sv),
      .d_i    (sp),
      .do_mul (gm[FRAC_BITS-k]),
      .vld_o  (fv[k]),
      .d_o    (fp[k])
    );
  end

  assign vld_o = fv[FRAC_BITS];
  assign d_o   = fp[FRAC_BITS];

endmodule

/* hdl/gray_gamma_correct.sv */
// Weighted grayscale conversion with gamma correction.
// Input channel: in_valid / in_stall with red_in, green_in, blue_in, one
// pixel per item. Output channel: out_valid / out_stall with gray_out.
// Config: cfg_valid / cfg_ready (always ready), cfg_index selects weight_red,
// weight_green, weight_blue or gamma_value; write only while the block is idle.
// Throughput: one item per cycle while out_stall does not hold the pipeline.
// Pipeline, in order: weighted sum, 8-step divider, x setup, one multiplier
// per integer step, a 32-step square root plus a multiplier per fraction
// bit, and the output register.
// The pipeline moves as one: when the output holds an item and out_stall is
// high, every stage holds and in_stall is raised.
// Reset (rst_n low, synchronous) clears all valid bits and loads the
// registers with weights 256, 256, 256 and gamma 1.0.
module gray_gamma_correct import ggc_pkg::*; #(
  parameter int FRAC_BITS = 12,
  parameter int INT_BITS  = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        red_in,
  input  logic [7:0]        green_in,
  input  logic [7:0]        blue_in,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        gray_out,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_data
);

  localparam int GW = INT_BITS + FRAC_BITS;

  logic [CFG_DW-1:0] w_red_r, w_green_r, w_blue_r, gamma_r;
  logic [GW-1:0]     gm;
  logic              en;
  logic              mv;
  logic [7:0]        md;
  logic              pv;
  pw_t               pd;
  logic [PW+7:0]     scaled;
  logic [7:0]        gray_nxt;
  logic              out_valid_r;
  logic [7:0]        gray_r;

  assign cfg_ready = 1'b1;
  assign en        = !(out_valid_r && out_stall);
  assign in_stall  = !en;
  assign gm        = GW'(gamma_r);

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_red_r   <= CFG_DW'(256);
      w_green_r <= CFG_DW'(256);
      w_blue_r  <= CFG_DW'(256);
      gamma_r   <= CFG_DW'(4096);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_WEIGHT_RED:   w_red_r   <= cfg_data;
        REG_WEIGHT_GREEN: w_green_r <= cfg_data;
        REG_WEIGHT_BLUE:  w_blue_r  <= cfg_data;
        REG_GAMMA_VALUE:  gamma_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  ggc_mean u_mean (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .vld_i   (in_valid),
    .red_i   (red_in),
    .green_i (green_in),
    .blue_i  (blue_in),
    .w_red   (w_red_r),
    .w_green (w_green_r),
    .w_blue  (w_blue_r),
    .vld_o   (mv),
    .d_o     (md)
  );

  ggc_power #(
    .INT_BITS  (INT_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_power (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .vld_i (mv),
    .d_i   (md),
    .gm    (gm),
    .vld_o (pv),
    .d_o   (pd)
  );

  // scale back to 0..255, special cases for zero gamma and zero gray
  always_comb begin
    scaled = ((PW+8)'(pd.p) << 8) - (PW+8)'(pd.p);
    if (gm == '0) begin
      gray_nxt = 8'd255;
    end else if (pd.dz) begin
      gray_nxt = 8'd0;
    end else begin
      gray_nxt = scaled[FX+7:FX];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= pv;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      gray_r <= gray_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign gray_out  = gray_r;

endmodule
